/* rtl/lgrs_pkg.sv */
package lgrs_pkg;

    localparam int ROW_BITS      = 64;
    localparam int WIDTH_BITS    = 7;
    localparam int MAX_ROW_WIDTH = 64;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LVL_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef logic [ROW_BITS-1:0] t_row;

    typedef struct packed {
        t_row row_bits;
        logic first_row;
        logic last_row;
    } t_in_beat;

    typedef struct packed {
        t_row next_row_bits;
        logic grid_done;
    } t_out_beat;

    typedef struct packed {
        t_row above;
        t_row middle;
        t_row below;
        logic done;
    } t_job;

    typedef struct packed {
        logic [1:0] count;
        t_job       job0;
        t_job       job1;
    } t_push;

    function automatic t_row width_mask(input logic [WIDTH_BITS-1:0] width);
        logic [WIDTH_BITS-1:0] eff;
        t_row                  mask;
        eff = (width > WIDTH_BITS'(MAX_ROW_WIDTH)) ? WIDTH_BITS'(MAX_ROW_WIDTH) : width;
        for (int k = 0; k < ROW_BITS; k++) begin
            mask[k] = (WIDTH_BITS'(k) < eff);
        end
        return mask;
    endfunction

endpackage

/* rtl/lgrs_front.sv */
module lgrs_front
    import lgrs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_beat i_beat,
    input  t_row     i_mask,
    output t_push    o_push
);

    logic r_mid_valid;
    t_row r_above;
    t_row r_mid;

    logic n_mid_valid;
    t_row n_above;
    t_row n_mid;

    always_comb begin
        logic mv;
        t_row row;
        t_row above;
        t_row mid;
        t_row keep_above;
        t_job job_a;
        t_job job_b;
        mv    = r_mid_valid && !i_beat.first_row;
        row   = i_beat.row_bits & i_mask;
        above = mv ? r_above : '0;
        mid   = mv ? r_mid : '0;
        keep_above = mv ? mid : '0;

        job_a = '{above: above, middle: mid, below: row, done: 1'b0};
        job_b = '{above: keep_above, middle: row, below: '0, done: 1'b1};

        o_push.count = i_accept ? ({1'b0, mv} + {1'b0, i_beat.last_row}) : 2'd0;
        o_push.job0  = mv ? job_a : job_b;
        o_push.job1  = job_b;

        n_mid_valid = r_mid_valid;
        n_above     = r_above;
        n_mid       = r_mid;
        if (i_accept) begin
            n_mid_valid = !i_beat.last_row;
            n_above     = i_beat.last_row ? '0 : keep_above;
            n_mid       = i_beat.last_row ? '0 : row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else begin
            r_mid_valid <= n_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_above <= n_above;
        r_mid   <= n_mid;
    end

endmodule

/* rtl/lgrs_queue.sv */
module lgrs_queue
    import lgrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_push                  i_push,
    input  logic                   i_pop,
    output logic                   o_valid,
    output t_job                   o_head,
    output logic [QUEUE_LVL_W-1:0] o_level
);

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] r_head;
    logic [QUEUE_IDX_W-1:0] r_tail;
    logic [QUEUE_LVL_W-1:0] r_level;

    logic [QUEUE_IDX_W-1:0] n_head;
    logic [QUEUE_IDX_W-1:0] n_tail;
    logic [QUEUE_LVL_W-1:0] n_level;
    logic [QUEUE_IDX_W-1:0] tail_next;

    assign tail_next = r_tail + QUEUE_IDX_W'(1);
    assign o_valid   = (r_level != '0);
    assign o_head    = r_mem[r_head];
    assign o_level   = r_level;

    always_comb begin
        logic do_pop;
        do_pop  = i_pop && o_valid;
        n_head  = do_pop ? r_head + QUEUE_IDX_W'(1) : r_head;
        n_tail  = r_tail + QUEUE_IDX_W'(i_push.count);
        n_level = r_level + QUEUE_LVL_W'(i_push.count) - QUEUE_LVL_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.job0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[tail_next] <= i_push.job1;
        end
    end

endmodule

/* rtl/lgrs_back.sv */
module lgrs_back
    import lgrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    input  t_row      i_mask,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    logic      r_out_valid;
    t_out_beat r_out_data;
    t_row      next_row;

    logic [ROW_BITS+1:0] pad_above;
    logic [ROW_BITS+1:0] pad_mid;
    logic [ROW_BITS+1:0] pad_below;

    assign pad_above = {1'b0, i_job.above & i_mask, 1'b0};
    assign pad_mid   = {1'b0, i_job.middle & i_mask, 1'b0};
    assign pad_below = {1'b0, i_job.below & i_mask, 1'b0};

    for (genvar c = 0; c < ROW_BITS; c++) begin : g_cell
        logic [3:0] n;
        logic       alive;
        assign n = 4'(pad_above[c]) + 4'(pad_above[c+1]) + 4'(pad_above[c+2])
                 + 4'(pad_mid[c]) + 4'(pad_mid[c+2])
                 + 4'(pad_below[c]) + 4'(pad_below[c+1]) + 4'(pad_below[c+2]);
        assign alive = pad_mid[c+1];
        assign next_row[c] = i_mask[c] &&
            (alive ? (n == SURVIVE_COUNT || n == BIRTH_COUNT) : (n == BIRTH_COUNT));
    end

    assign o_pop       = i_job_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= '{next_row_bits: next_row, grid_done: i_job.done};
        end
    end

endmodule

/* rtl/life_generation_row_stencil.sv */
// Next generation of the B3/S23 cellular automaton, one 64-bit grid row per beat,
// top row first. A row beat is taken every cycle unless o_in_stall is high; the
// result for a row leaves one input row later, and a beat marked last row also
// yields the final row of the grid with grid_done set, so such a beat produces two
// result beats unless it is the only row of its grid. The output side delivers one
// result beat per cycle unless i_out_stall is high, from a four-entry job queue,
// which sets the sustained rate at one row per cycle for grids of two or more rows.
// A completed job is held in the job queue, then in the output register.
// Cells beyond row_width, above the top row and below the bottom row are dead;
// row_width may only be written while no results are outstanding.
module life_generation_row_stencil
    import lgrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_wr_en,
    input  logic [WIDTH_BITS-1:0] i_cfg_wr_data
);

    t_row                   r_mask;
    t_push                  push;
    logic                   in_accept;
    logic                   q_valid;
    t_job                   q_head;
    logic [QUEUE_LVL_W-1:0] q_level;
    logic                   pop;

    assign o_in_stall = (q_level > QUEUE_LVL_W'(QUEUE_DEPTH - 2));
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= width_mask(WIDTH_BITS'(MAX_ROW_WIDTH));
        end else if (i_cfg_wr_en) begin
            r_mask <= width_mask(i_cfg_wr_data);
        end
    end

    lgrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_beat   (i_in_data),
        .i_mask   (r_mask),
        .o_push   (push)
    );

    lgrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_level (q_level)
    );

    lgrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_head),
        .i_mask      (r_mask),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= QUEUE_LVL_W'(QUEUE_DEPTH))
        else $error("job queue overflow");

    a_last_row_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_in_data.last_row |=> (q_level != '0) || o_out_valid)
        else $error("last row beat produced no pending result");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> push.count == 2'd0)
        else $error("job pushed while input stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && q_level == '0)
        else $error("results present after reset");

endmodule
